// File: sv/bace_pkg.sv
// ----------------------------------------------------------------------------
// bace_pkg: shared types and functions of the address checksum engine
// GF(32) BCH generator terms, the shift-and-reduce step, charset lookup
// and the payload types of both channels and the final-residue request.
// ----------------------------------------------------------------------------
package bace_pkg;

  localparam int unsigned ResW = 40;
  localparam int unsigned SymW = 5;
  localparam int unsigned ChrW = 7;

  // generator terms, one per bit of the top symbol
  localparam logic [ResW-1:0] GEN [SymW] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
    40'hae2eabe2a8, 40'h1e4f43e470
  };

  localparam logic [ResW-1:0] RES_INIT = 40'd1;

  // ascii charset, indexed by symbol
  localparam logic [ChrW-1:0] CHARSET [32] = '{
    7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
    7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
    7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
    7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
  };

  typedef struct packed {
    logic [7:0] value;
    logic       is_prefix;
    logic       last;
  } bace_in_t;

  typedef struct packed {
    logic [SymW-1:0] check_symbol;
    logic [ChrW-1:0] check_char;
    logic            checksum_ok;
    logic            symbol_error;
    logic            last_out;
  } bace_out_t;

  // finished address handed down the pipeline
  typedef struct packed {
    logic [ResW-1:0] residue;
    logic            error;
    logic            verify;
  } bace_fin_t;

  // one shift-and-reduce step with one symbol
  function automatic logic [ResW-1:0] fold(input logic [ResW-1:0] res,
                                           input logic [SymW-1:0] sym);
    logic [SymW-1:0] top;
    logic [ResW-1:0] r;
    top = res[ResW-1:ResW-SymW];
    r   = {res[ResW-SymW-1:0], {SymW{1'b0}}} ^ {{(ResW-SymW){1'b0}}, sym};
    for (int b = 0; b < SymW; b++) begin
      if (top[b]) r = r ^ GEN[b];
    end
    return r;
  endfunction

  // four zero-symbol steps
  function automatic logic [ResW-1:0] fold4_zero(input logic [ResW-1:0] res);
    logic [ResW-1:0] r;
    r = res;
    for (int k = 0; k < 4; k++) begin
      r = fold(r, {SymW{1'b0}});
    end
    return r;
  endfunction

endpackage

// File: sv/bace_accum.sv
// ----------------------------------------------------------------------------
// bace_accum: residue accumulator
// Folds prefix and payload symbols into the running residue, inserts the
// separator, tracks payload range errors and hands finished addresses on.
// ----------------------------------------------------------------------------
module bace_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  bace_pkg::bace_in_t in_data_i,
  input  logic               fin_stall_i,
  output logic               in_stall_o,
  output logic               fin_valid_o,
  output bace_pkg::bace_fin_t fin_data_o
);

  logic [bace_pkg::ResW-1:0] res_q, res_d;
  logic                      sep_q, sep_d;
  logic                      err_q, err_d;
  logic                      mode_q;
  logic                      accept;
  logic [bace_pkg::ResW-1:0] r_new;
  logic                      sep_new;
  logic                      err_new;

  // only a last request needs room in the pad stage
  assign in_stall_o = fin_stall_i & in_data_i.last;
  assign accept     = in_valid_i & ~in_stall_o;

  // fold of one request, separator before first payload or at the end
  always_comb begin
    r_new   = res_q;
    sep_new = sep_q;
    err_new = err_q;
    if (in_data_i.is_prefix) begin
      r_new = bace_pkg::fold(res_q, in_data_i.value[4:0]);
    end else begin
      if (!sep_q) r_new = bace_pkg::fold(res_q, 5'd0);
      r_new   = bace_pkg::fold(r_new, in_data_i.value[4:0]);
      sep_new = 1'b1;
      if (in_data_i.value[7:5] != 3'd0) err_new = 1'b1;
    end
    if (in_data_i.last && !sep_new) begin
      r_new = bace_pkg::fold(r_new, 5'd0);
    end
  end

  // next state, cleared at the end of an address
  always_comb begin
    res_d = res_q;
    sep_d = sep_q;
    err_d = err_q;
    if (accept) begin
      if (in_data_i.last) begin
        res_d = bace_pkg::RES_INIT;
        sep_d = 1'b0;
        err_d = 1'b0;
      end else begin
        res_d = r_new;
        sep_d = sep_new;
        err_d = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= bace_pkg::RES_INIT;
      sep_q  <= 1'b0;
      err_q  <= 1'b0;
      mode_q <= 1'b0;
    end else begin
      res_q <= res_d;
      sep_q <= sep_d;
      err_q <= err_d;
      if (cfg_we_i) mode_q <= cfg_data_i;
    end
  end

  // finished address request
  assign fin_valid_o        = accept & in_data_i.last;
  assign fin_data_o.residue = r_new;
  assign fin_data_o.error   = err_new;
  assign fin_data_o.verify  = mode_q;

endmodule

// File: sv/bace_pad.sv
// ----------------------------------------------------------------------------
// bace_pad: zero padding stage
// In create mode folds eight zero symbols into the final residue, four per
// cycle in two steps; verify requests pass straight through.
// ----------------------------------------------------------------------------
module bace_pad (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fin_valid_i,
  input  bace_pkg::bace_fin_t fin_data_i,
  output logic                fin_stall_o,
  input  logic                emit_stall_i,
  output logic                emit_valid_o,
  output bace_pkg::bace_fin_t emit_data_o
);

  logic                valid_q, valid_d;
  logic [1:0]          steps_q, steps_d;
  bace_pkg::bace_fin_t data_q, data_d;
  logic                handoff;
  logic                load;

  assign emit_valid_o = valid_q & (steps_q == 2'd0);
  assign handoff      = emit_valid_o & ~emit_stall_i;
  assign fin_stall_o  = valid_q & ~handoff;
  assign load         = fin_valid_i & ~fin_stall_o;
  assign emit_data_o  = data_q;

  // load, pad steps and handoff
  always_comb begin
    valid_d = valid_q;
    steps_d = steps_q;
    data_d  = data_q;
    if (handoff) valid_d = 1'b0;
    if (steps_q != 2'd0) begin
      steps_d        = steps_q - 2'd1;
      data_d.residue = bace_pkg::fold4_zero(data_q.residue);
    end
    if (load) begin
      valid_d = 1'b1;
      steps_d = fin_data_i.verify ? 2'd0 : 2'd2;
      data_d  = fin_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      steps_q <= 2'd0;
    end else begin
      valid_q <= valid_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: sv/bace_emit.sv
// ----------------------------------------------------------------------------
// bace_emit: result register
// Shifts out the eight checksum symbols high group first with their charset
// characters, or presents one pass/fail result in verify mode.
// ----------------------------------------------------------------------------
module bace_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_valid_i,
  input  bace_pkg::bace_fin_t emit_data_i,
  output logic                emit_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bace_pkg::bace_out_t out_data_o
);

  logic                      valid_q, valid_d;
  logic [2:0]                idx_q, idx_d;
  logic [bace_pkg::ResW-1:0] sh_q, sh_d;
  logic                      verify_q, verify_d;
  logic                      err_q, err_d;
  logic                      ok_q, ok_d;
  logic                      done;
  logic                      fire;
  logic                      load;
  logic [bace_pkg::SymW-1:0] sym;

  assign done         = verify_q | (idx_q == 3'd7);
  assign fire         = valid_q & ~out_stall_i;
  assign emit_stall_o = valid_q & ~(fire & done);
  assign load         = emit_valid_i & ~emit_stall_o;

  // shift and load
  always_comb begin
    valid_d  = valid_q;
    idx_d    = idx_q;
    sh_d     = sh_q;
    verify_d = verify_q;
    err_d    = err_q;
    ok_d     = ok_q;
    if (fire) begin
      if (done) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
        sh_d  = {sh_q[bace_pkg::ResW-bace_pkg::SymW-1:0], {bace_pkg::SymW{1'b0}}};
      end
    end
    if (load) begin
      valid_d  = 1'b1;
      idx_d    = 3'd0;
      sh_d     = emit_data_i.residue ^ bace_pkg::RES_INIT;
      verify_d = emit_data_i.verify;
      err_d    = emit_data_i.error;
      ok_d     = (emit_data_i.residue == bace_pkg::RES_INIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q     <= sh_d;
    verify_q <= verify_d;
    err_q    <= err_d;
    ok_q     <= ok_d;
  end

  // result fields
  assign sym         = sh_q[bace_pkg::ResW-1:bace_pkg::ResW-bace_pkg::SymW];
  assign out_valid_o = valid_q;
  assign out_data_o.check_symbol = verify_q ? '0 : sym;
  assign out_data_o.check_char   = verify_q ? '0 : bace_pkg::CHARSET[sym];
  assign out_data_o.checksum_ok  = verify_q & ok_q;
  assign out_data_o.symbol_error = err_q;
  assign out_data_o.last_out     = done;

endmodule

// File: sv/bch_address_checksum_engine_unit.sv
// ----------------------------------------------------------------------------
// Path: a last request is registered in the pad stage, then in the result
//   register; create mode first takes two 4-symbol zero padding steps.
// Throughput: one request per cycle unless a last one waits on the pad;
//   8 create results stream out of the result register; pad holds the next.
// Reset: rst_ni clears residue to 1, the separator and error flags, mode to
//   create, and empties the pad and result stages.
// ----------------------------------------------------------------------------
// bch_address_checksum_engine_unit: streaming GF(32) BCH address checksum
// Accumulator, zero padding stage and result register in a short pipeline.
// ----------------------------------------------------------------------------
module bch_address_checksum_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bace_pkg::bace_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bace_pkg::bace_out_t out_data_o
);

  logic                fin_valid;
  logic                fin_stall;
  bace_pkg::bace_fin_t fin_data;
  logic                emit_valid;
  logic                emit_stall;
  bace_pkg::bace_fin_t emit_data;

  // residue accumulator
  bace_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .fin_stall_i (fin_stall),
    .in_stall_o  (in_stall_o),
    .fin_valid_o (fin_valid),
    .fin_data_o  (fin_data)
  );

  // zero padding
  bace_pad u_pad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_valid_i  (fin_valid),
    .fin_data_i   (fin_data),
    .fin_stall_o  (fin_stall),
    .emit_stall_i (emit_stall),
    .emit_valid_o (emit_valid),
    .emit_data_o  (emit_data)
  );

  // result register
  bace_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_data_i  (emit_data),
    .emit_stall_o (emit_stall),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // a passing verify result carries no symbol and ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.checksum_ok |->
      out_data_o.last_out && (out_data_o.check_symbol == 5'd0))
    else $error("verify result with symbol or without last_out");

  // a finished address is never dropped at the pad stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid |-> !fin_stall)
    else $error("finished address offered while pad stage busy");

  // a handoff to the result register is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid && !emit_stall |=> out_valid_o)
    else $error("handoff lost before result register");

endmodule

// File: test/bch_address_checksum_engine_unit_test.sv
// ----------------------------------------------------------------------------
// bch_address_checksum_engine_unit_test: self-checking bench of the checksum engine
// Drives addresses as prefix and payload requests under random idling and one long
// receiver hold-off, and checks each result against a GF(32) BCH model of its own.
// ----------------------------------------------------------------------------
module bch_address_checksum_engine_unit_test;

  typedef enum logic {MODE_CREATE = 1'b0, MODE_VERIFY = 1'b1} mode_e;

  localparam int unsigned RANDOM_ITEMS   = 295;
  localparam int unsigned IDLE_PCT       = 15;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AFTER     = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned NUM_DIRECTED   = 25;

  // reduction terms, one per bit of the symbol shifted out
  localparam logic [39:0] GEN_TERM [5] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
    40'hae2eabe2a8, 40'h1e4f43e470
  };

  // charset, symbol 0 in the top byte
  localparam logic [255:0] CHAR_LUT = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [39:0] acc;
    logic        sep_done;
    logic        err_seen;
  } addr_state_t;

  localparam addr_state_t ADDR_IDLE = '{acc: 40'd1, sep_done: 1'b0, err_seen: 1'b0};

  // directed row: exp_chars holds the typed check string of a create address
  typedef struct packed {
    logic        mode;
    logic [7:0]  value;
    logic        is_prefix;
    logic        last;
    logic        typed;
    logic [63:0] exp_chars;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // create: prefix only, separator folded in at the end
    '{1'b0, "p", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b0, "r", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b0, "e", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b0, "f", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b0, "i", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b0, "x", 1'b1, 1'b1, 1'b1, "x64nx6hz"},
    // verify: same prefix with its check symbols as payload
    '{1'b1, "p", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, "r", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, "e", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, "f", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, "i", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, "x", 1'b1, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd6,  1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd26, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd21, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd19, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd6,  1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd26, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd23, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'd2,  1'b0, 1'b1, 1'b1, 64'd0},
    // create: largest payload byte, error flag
    '{1'b0, 8'hff, 1'b0, 1'b1, 1'b0, 64'd0},
    // verify: zero payload, then a prefix byte after payload
    '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 8'hff, 1'b1, 1'b1, 1'b0, 64'd0},
    // verify: smallest out-of-range payload
    '{1'b1, 8'h20, 1'b0, 1'b1, 1'b0, 64'd0},
    // create: largest legal payload symbol
    '{1'b0, 8'h1f, 1'b0, 1'b1, 1'b0, 64'd0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_data_i  = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  bace_pkg::bace_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bace_pkg::bace_out_t out_data_o;

  // model state, configuration and results still to arrive
  addr_state_t         addr_q = ADDR_IDLE;
  mode_e               mode_q = MODE_CREATE;
  bace_pkg::bace_out_t checksum_results_q [$];
  bace_pkg::bace_in_t  address_items [$];
  bace_pkg::bace_out_t oldest_result;

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;
  logic        hold_done      = 1'b0;
  logic        quiet          = 1'b0;

  bch_address_checksum_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // shift one symbol in, reduce by the terms of the symbol shifted out
  function automatic logic [39:0] bch_fold(logic [39:0] acc, logic [4:0] sym);
    logic [39:0] nxt;
    nxt = {acc[34:0], sym};
    for (int b = 0; b < 5; b++) begin
      if (acc[35+b]) nxt = nxt ^ GEN_TERM[b];
    end
    return nxt;
  endfunction

  // absorb one request, separator included
  function automatic addr_state_t absorb_item(addr_state_t s, bace_pkg::bace_in_t item);
    addr_state_t n;
    n = s;
    if (!item.is_prefix) begin
      if (!n.sep_done) begin
        n.acc      = bch_fold(n.acc, 5'd0);
        n.sep_done = 1'b1;
      end
      if (item.value > 8'd31) n.err_seen = 1'b1;
    end
    n.acc = bch_fold(n.acc, item.value[4:0]);
    if (item.last && !n.sep_done) begin
      n.acc      = bch_fold(n.acc, 5'd0);
      n.sep_done = 1'b1;
    end
    return n;
  endfunction

  // eight zero symbols of padding, then the final xor
  function automatic logic [39:0] create_check(logic [39:0] acc);
    logic [39:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) r = bch_fold(r, 5'd0);
    return r ^ 40'd1;
  endfunction

  function automatic logic [6:0] char_of(logic [4:0] sym);
    int unsigned k;
    logic [7:0]  c;
    k = sym;
    c = CHAR_LUT[255 - 8*k -: 8];
    return c[6:0];
  endfunction

  // create checksum of a request list, its final entry taken as last
  function automatic logic [39:0] checksum_for(bace_pkg::bace_in_t items [$]);
    addr_state_t        s;
    bace_pkg::bace_in_t it;
    s = ADDR_IDLE;
    foreach (items[k]) begin
      it      = items[k];
      it.last = (k == items.size() - 1);
      s       = absorb_item(s, it);
    end
    return create_check(s.acc);
  endfunction

  // append one expected result behind the others
  function automatic void expect_result(bace_pkg::bace_out_t r);
    checksum_results_q = {checksum_results_q, r};
  endfunction

  // update the model with one accepted request, queue its results
  task automatic predict_request(input bace_pkg::bace_in_t item, input bit keep);
    bace_pkg::bace_out_t r;
    logic [39:0]         chk;
    addr_q = absorb_item(addr_q, item);
    if (item.last) begin
      if (mode_q == MODE_CREATE) begin
        chk = create_check(addr_q.acc);
        for (int i = 0; i < 8; i++) begin
          r.check_symbol = chk[39 - 5*i -: 5];
          r.check_char   = char_of(r.check_symbol);
          r.checksum_ok  = 1'b0;
          r.symbol_error = addr_q.err_seen;
          r.last_out     = (i == 7);
          if (keep) expect_result(r);
        end
      end else begin
        r              = '0;
        r.checksum_ok  = ((addr_q.acc ^ 40'd1) == 40'd0);
        r.symbol_error = addr_q.err_seen;
        r.last_out     = 1'b1;
        if (keep) expect_result(r);
      end
      addr_q = ADDR_IDLE;
    end
  endtask

  // offer one request until accepted, with random idle cycles first
  task automatic offer_request(input bace_pkg::bace_in_t item, input bit keep);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(item, keep);
  endtask

  // drain the block, then write the mode register
  task automatic set_mode(input mode_e m);
    in_valid_i <= 1'b0;
    while (checksum_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mode_q = m;
  endtask

  // one random address: mostly well formed, verify ones carry their check symbols
  task automatic build_address();
    int unsigned        kind;
    int unsigned        npre;
    int unsigned        npay;
    int unsigned        k;
    logic [39:0]        chk;
    bace_pkg::bace_in_t it;
    address_items.delete();
    kind = $urandom_range(9);
    if (kind < 7) begin
      npre = $urandom_range(6);
      npay = ($urandom_range(7) == 0) ? 0 : $urandom_range(10, 1);
      if (npre + npay == 0) npre = 1;
      it.last = 1'b0;
      it.is_prefix = 1'b1;
      for (int i = 0; i < npre; i++) begin
        it.value = ($urandom_range(3) != 0) ? 8'($urandom_range(8'h7a, 8'h61))
                                            : 8'($urandom_range(255));
        address_items = {address_items, it};
      end
      it.is_prefix = 1'b0;
      for (int i = 0; i < npay; i++) begin
        it.value = 8'($urandom_range(31));
        address_items = {address_items, it};
      end
      if (mode_q == MODE_VERIFY) begin
        chk = checksum_for(address_items);
        for (int i = 0; i < 8; i++) begin
          it.value = {3'b000, chk[39 - 5*i -: 5]};
          address_items = {address_items, it};
        end
        // broken address: one symbol changed
        if ($urandom_range(3) == 0) begin
          k = $urandom_range(address_items.size() - 1);
          address_items[k].value = address_items[k].value ^ 8'($urandom_range(31, 1));
        end
      end
    end else begin
      // noise: any byte, any kind
      npre = $urandom_range(6, 1);
      for (int i = 0; i < npre; i++) begin
        it.value     = 8'($urandom_range(255));
        it.is_prefix = 1'($urandom_range(1));
        it.last      = 1'b0;
        address_items = {address_items, it};
      end
    end
    address_items[address_items.size() - 1].last = 1'b1;
  endtask

  // stimulus: reset, directed table, random addresses, drain
  initial begin
    dir_row_t            row;
    bace_pkg::bace_in_t  item;
    bace_pkg::bace_out_t r;
    logic [6:0]          c;
    int unsigned         sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (i == 0 || row.mode != mode_q) set_mode(mode_e'(row.mode));
      item.value     = row.value;
      item.is_prefix = row.is_prefix;
      item.last      = row.last;
      offer_request(item, !row.typed);
      if (row.typed) begin
        if (row.mode == MODE_CREATE) begin
          for (int j = 0; j < 8; j++) begin
            c = row.exp_chars[62 - 8*j -: 7];
            r = '0;
            r.check_char = c;
            for (int s = 0; s < 32; s++) begin
              if (char_of(5'(s)) == c) r.check_symbol = 5'(s);
            end
            r.last_out = (j == 7);
            expect_result(r);
          end
        end else begin
          r             = '0;
          r.checksum_ok = 1'b1;
          r.last_out    = 1'b1;
          expect_result(r);
        end
      end
    end

    // random addresses
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet <= (sent >= 100 && sent < 180);
      if (hold_left == 0 && $urandom_range(5) == 0) set_mode(mode_e'($urandom_range(1)));
      build_address();
      foreach (address_items[k]) begin
        offer_request(address_items[k], 1'b1);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain and settle
    while (checksum_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: compare with the oldest expectation, random stall, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (checksum_results_q.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        mismatch_count++;
      end else begin
        oldest_result = checksum_results_q.pop_front();
        if (out_data_o.check_symbol !== oldest_result.check_symbol) begin
          $error("check_symbol expected %0d actual %0d",
                 oldest_result.check_symbol, out_data_o.check_symbol);
          mismatch_count++;
        end
        if (out_data_o.check_char !== oldest_result.check_char) begin
          $error("check_char expected %0h actual %0h",
                 oldest_result.check_char, out_data_o.check_char);
          mismatch_count++;
        end
        if (out_data_o.checksum_ok !== oldest_result.checksum_ok) begin
          $error("checksum_ok expected %0d actual %0d",
                 oldest_result.checksum_ok, out_data_o.checksum_ok);
          mismatch_count++;
        end
        if (out_data_o.symbol_error !== oldest_result.symbol_error) begin
          $error("symbol_error expected %0d actual %0d",
                 oldest_result.symbol_error, out_data_o.symbol_error);
          mismatch_count++;
        end
        if (out_data_o.last_out !== oldest_result.last_out) begin
          $error("last_out expected %0d actual %0d",
                 oldest_result.last_out, out_data_o.last_out);
          mismatch_count++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
    out_stall_i <= (hold_left != 0) || (!quiet && ($urandom_range(99) < IDLE_PCT));
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
